[hw/rtl/crks_pkg.sv]
package crks_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned ValW    = 16;
  localparam int unsigned CntW    = 7;
  localparam int unsigned MaxKeys = 64;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_EXACT  = 2'd1,
    ST_CLAMP  = 2'd2,
    ST_WRITE  = 2'd3
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Front-end item handed to the back end through the queue
  typedef struct packed {
    logic              op;
    logic [5:0]        key_index;
    logic [TimeW-1:0]  key_time;
    logic [ValW-1:0]   value_x;
    logic [ValW-1:0]   value_y;
    logic [ValW-1:0]   value_z;
    logic [TimeW-1:0]  query_time;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_WRITE, BK_SRCH_RD, BK_SRCH, BK_T0_RD, BK_T0, BK_DIV,
    BK_WGT, BK_VAL_RD, BK_MAC, BK_NEXT, BK_EMIT_RD, BK_EMIT, BK_OUT
  } bk_state_e;

endpackage

[hw/rtl/crks_if.sv]
interface crks_in_if;
  logic                 valid;
  logic                 ready;
  crks_pkg::item_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crks_out_if;
  logic                      valid;
  logic                      ready;
  logic [crks_pkg::ValW-1:0] out_x;
  logic [crks_pkg::ValW-1:0] out_y;
  logic [crks_pkg::ValW-1:0] out_z;
  logic [1:0]                status;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output status, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input status, output ready);
endinterface

interface crks_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [crks_pkg::CntW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/crks_queue.sv]
// Two-entry request queue between front and back end
module crks_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crks_pkg::item_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output crks_pkg::item_t pop_data_o
);
  crks_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end
endmodule

[hw/rtl/crks_front.sv]
// Front end: takes requests, masks unused dimensions, pushes to the queue
module crks_front #(
  parameter int unsigned DIM = 3
) (
  crks_in_if.sink         in_if,
  output logic            push_o,
  output crks_pkg::item_t push_data_o,
  input  logic            full_i
);
  assign in_if.ready = ~full_i;
  assign push_o      = in_if.valid & ~full_i;

  always_comb begin
    push_data_o = in_if.data;
    if (DIM < 2) push_data_o.value_y = '0;
    if (DIM < 3) push_data_o.value_z = '0;
  end
endmodule

[hw/rtl/crks_back.sv]
// Back end: key store, linear search, serial divide, weights and MAC
module crks_back #(
  parameter int unsigned DIM      = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [crks_pkg::CntW-1:0]  keys_in_use_i,
  input  logic                       empty_i,
  input  crks_pkg::item_t            item_i,
  output logic                       pop_o,
  crks_out_if.source                 out_if
);
  localparam int unsigned AW = $clog2(crks_pkg::MaxKeys);
  localparam int unsigned NW = $clog2(crks_pkg::MaxKeys + 1);

  crks_pkg::bk_state_e state_q, state_d;

  // key memories, one read port each
  logic [15:0] tmem [crks_pkg::MaxKeys];
  logic [15:0] vmem [crks_pkg::MaxKeys][3];
  logic [AW-1:0] taddr, vaddr;
  logic [15:0] trd_q;
  logic [15:0] vrd_q [3];
  logic        twe;

  crks_pkg::item_t it_q;
  logic [NW-1:0] n_q, k_q;
  logic [15:0]   t0_q, t1_q;
  logic [16:0]   rem_q;
  logic [16:0]   h_q;
  logic [33:0]   h2_q;
  logic [50:0]   h3_q;
  logic [4:0]    cnt_q;
  logic [1:0]    i_q;
  logic signed [18:0] w_q [4];
  logic signed [47:0] acc_q [3];
  logic [15:0]   ox_q, oy_q, oz_q;
  logic [1:0]    st_q;
  logic          ov_q;

  // effective key count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (keys_in_use_i == '0) n_eff = NW'(1);
    else if ({{(32-crks_pkg::CntW){1'b0}}, keys_in_use_i} > crks_pkg::MaxKeys)
      n_eff = NW'(crks_pkg::MaxKeys);
    else n_eff = NW'(keys_in_use_i);
  end

  assign twe = state_q == crks_pkg::BK_WRITE &&
               {{(32-6){1'b0}}, it_q.key_index} < crks_pkg::MaxKeys;

  always_ff @(posedge clk_i) begin
    if (twe) begin
      tmem[it_q.key_index[AW-1:0]]    <= it_q.key_time;
      vmem[it_q.key_index[AW-1:0]][0] <= it_q.value_x;
      vmem[it_q.key_index[AW-1:0]][1] <= it_q.value_y;
      vmem[it_q.key_index[AW-1:0]][2] <= it_q.value_z;
    end
    trd_q    <= tmem[taddr];
    vrd_q[0] <= vmem[vaddr][0];
    vrd_q[1] <= vmem[vaddr][1];
    vrd_q[2] <= vmem[vaddr][2];
  end

  // neighbor index clamped to the table
  logic signed [NW+1:0] kn;
  logic [NW-1:0]        kn_c;
  always_comb begin
    kn = $signed({2'b00, k_q}) + $signed({{NW{1'b0}}, i_q}) - (NW+2)'(2);
    if (kn < 0) kn_c = '0;
    else if (kn > $signed({2'b00, n_q}) - (NW+2)'(1)) kn_c = n_q - NW'(1);
    else kn_c = kn[NW-1:0];
  end

  always_comb begin
    taddr = k_q[AW-1:0];
    if (state_q == crks_pkg::BK_T0_RD) taddr = AW'(k_q - NW'(1));
    vaddr = kn_c[AW-1:0];
    if (state_q == crks_pkg::BK_EMIT_RD) vaddr = k_q[AW-1:0];
  end

  // restoring divider step: h = ((t-t0)<<16)/(t1-t0)
  logic [16:0] dsh, dsub;
  logic [15:0] dvs;
  assign dvs  = t1_q - t0_q;
  assign dsh  = {rem_q[15:0], 1'b0};
  assign dsub = dsh - {1'b0, dvs};

  // weight for one basis row, P/2 rounded; h^2 and h^3 are registered first
  logic signed [18:0] wcalc;
  logic signed [68:0] p, a3, a2, a1;
  logic [1:0]         wsel;
  assign wsel = 2'(cnt_q - 5'd2);
  assign a3   = $signed({18'b0, h3_q});
  assign a2   = $signed({19'b0, h2_q, 16'b0});
  assign a1   = $signed({20'b0, h_q, 32'b0});
  always_comb begin
    case (wsel)
      2'd0: p = (a2 <<< 1) - a3 - a1;
      2'd1: p = (a3 <<< 1) + a3 - (a2 <<< 2) - a2 + (69'sd1 <<< 49);
      2'd2: p = (a2 <<< 2) + a1 - (a3 <<< 1) - a3;
      default: p = a3 - a2;
    endcase
    wcalc = 19'((p + (69'sd1 <<< 32)) >>> 33);
  end

  function automatic logic [15:0] sat_round(input logic signed [47:0] a);
    logic signed [47:0] r;
    r = (a + 48'sd32768) >>> 16;
    if (r > 48'sd32767) return 16'h7fff;
    if (r < -48'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      crks_pkg::BK_IDLE:
        if (!empty_i && !ov_q) begin
          pop_o = 1'b1;
          state_d = item_i.op == crks_pkg::OP_WRITE ? crks_pkg::BK_WRITE
                                                      : crks_pkg::BK_SRCH_RD;
        end
      crks_pkg::BK_WRITE: state_d = crks_pkg::BK_OUT;
      crks_pkg::BK_SRCH_RD: state_d = crks_pkg::BK_SRCH;
      crks_pkg::BK_SRCH:
        if (trd_q >= it_q.query_time) begin
          if (trd_q == it_q.query_time || k_q == '0) state_d = crks_pkg::BK_EMIT_RD;
          else state_d = crks_pkg::BK_T0_RD;
        end else if (k_q + NW'(1) >= n_q) state_d = crks_pkg::BK_EMIT_RD;
        else state_d = crks_pkg::BK_SRCH_RD;
      crks_pkg::BK_T0_RD: state_d = crks_pkg::BK_T0;
      crks_pkg::BK_T0: state_d = crks_pkg::BK_DIV;
      crks_pkg::BK_DIV: if (cnt_q == 5'd15) state_d = crks_pkg::BK_WGT;
      crks_pkg::BK_WGT: if (cnt_q == 5'd5) state_d = crks_pkg::BK_VAL_RD;
      crks_pkg::BK_VAL_RD: state_d = crks_pkg::BK_MAC;
      crks_pkg::BK_MAC: state_d = crks_pkg::BK_NEXT;
      crks_pkg::BK_NEXT: state_d = i_q == 2'd0 ? crks_pkg::BK_OUT : crks_pkg::BK_VAL_RD;
      crks_pkg::BK_EMIT_RD: state_d = crks_pkg::BK_EMIT;
      crks_pkg::BK_EMIT: state_d = crks_pkg::BK_OUT;
      crks_pkg::BK_OUT: state_d = crks_pkg::BK_IDLE;
      default: state_d = crks_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crks_pkg::BK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == crks_pkg::BK_OUT) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      crks_pkg::BK_IDLE:
        if (pop_o) begin
          it_q <= item_i;
          n_q  <= n_eff;
          k_q  <= '0;
          ox_q <= '0; oy_q <= '0; oz_q <= '0;
          st_q <= crks_pkg::ST_WRITE;
        end
      crks_pkg::BK_SRCH:
        if (trd_q >= it_q.query_time) begin
          t1_q <= trd_q;
          st_q <= trd_q == it_q.query_time ? crks_pkg::ST_EXACT :
                  (k_q == '0 ? crks_pkg::ST_CLAMP : crks_pkg::ST_INTERP);
        end else if (k_q + NW'(1) >= n_q) begin
          st_q <= crks_pkg::ST_CLAMP;
        end else k_q <= k_q + NW'(1);
      crks_pkg::BK_T0: begin
        t0_q  <= trd_q;
        rem_q <= {1'b0, it_q.query_time - trd_q};
        h_q   <= '0;
        cnt_q <= '0;
      end
      crks_pkg::BK_DIV: begin
        // quotient < 2^16 since t-t0 < t1-t0; 16 steps
        if (!dsub[16]) begin
          rem_q <= dsub; h_q <= {h_q[15:0], 1'b1};
        end else begin
          rem_q <= dsh;  h_q <= {h_q[15:0], 1'b0};
        end
        cnt_q <= cnt_q == 5'd15 ? 5'd0 : cnt_q + 5'd1;
      end
      crks_pkg::BK_WGT: begin
        // the powers h^2 and h^3 first, then one weight per cycle
        if (cnt_q == 5'd0) h2_q <= h_q * h_q;
        else if (cnt_q == 5'd1) h3_q <= h2_q * h_q;
        else w_q[wsel] <= wcalc;
        cnt_q <= cnt_q + 5'd1;
        i_q   <= '0;
        acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0;
      end
      crks_pkg::BK_MAC: begin
        acc_q[0] <= acc_q[0] + 48'(w_q[i_q] * $signed(vrd_q[0]));
        acc_q[1] <= acc_q[1] + 48'(w_q[i_q] * $signed(vrd_q[1]));
        acc_q[2] <= acc_q[2] + 48'(w_q[i_q] * $signed(vrd_q[2]));
        i_q <= i_q + 2'd1;
      end
      crks_pkg::BK_NEXT:
        if (i_q == 2'd0) begin
          ox_q <= sat_round(acc_q[0]);
          oy_q <= DIM > 1 ? sat_round(acc_q[1]) : '0;
          oz_q <= DIM > 2 ? sat_round(acc_q[2]) : '0;
        end
      crks_pkg::BK_EMIT: begin
        ox_q <= vrd_q[0];
        oy_q <= DIM > 1 ? vrd_q[1] : '0;
        oz_q <= DIM > 2 ? vrd_q[2] : '0;
      end
      default: ;
    endcase
    if (state_q == crks_pkg::BK_SRCH && trd_q < it_q.query_time &&
        k_q + NW'(1) >= n_q) k_q <= n_q - NW'(1);
  end

  assign out_if.valid  = ov_q;
  assign out_if.out_x  = ox_q;
  assign out_if.out_y  = oy_q;
  assign out_if.out_z  = oz_q;
  assign out_if.status = st_q;
endmodule

[hw/rtl/catmull_rom_key_spline_unit.sv]
// Catmull-Rom key spline unit.
// A write passes through the WRITE and OUT states. A query compares one key
// per search step; interpolation adds a 16-step divider, the weight step and
// four VAL_RD/MAC/NEXT passes. The back end takes one request at a time.
// Reset clears control and sets the key count to 1; key memories stay unset.
module catmull_rom_key_spline_unit #(
  parameter int unsigned DIM      = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crks_in_if.sink     in_if,
  crks_cfg_if.sink    cfg_if,
  crks_out_if.source  out_if
);
  logic [crks_pkg::CntW-1:0] keys_q;
  logic            push, pop, full, empty;
  crks_pkg::item_t push_data, pop_data;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) keys_q <= crks_pkg::CntW'(1);
    else if (cfg_if.valid) keys_q <= cfg_if.data;
  end

  crks_front #(.DIM(DIM)) u_front (
    .in_if(in_if), .push_o(push), .push_data_o(push_data), .full_i(full));

  crks_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .push_data_i(push_data),
    .full_o(full), .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data));

  crks_back #(.DIM(DIM)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .keys_in_use_i(keys_q), .empty_i(empty),
    .item_i(pop_data), .pop_o(pop), .out_if(out_if));

  // queue never pops while empty nor pushes while full
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("push to full queue");
  // pending result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.status))
    else $error("result dropped");
endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumKeys = 64;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 200;

  // Directed request row; expectation typed in only where obvious
  typedef struct {
    logic        op;
    logic [5:0]  idx;
    logic [15:0] kt;
    logic [15:0] vx, vy, vz;
    logic [15:0] qt;
    bit          fixed;
    logic [15:0] ex, ey, ez;
    logic [1:0]  est;
  } row_t;

  typedef struct packed {
    logic [15:0] x, y, z;
    logic [1:0]  st;
  } spline_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crks_in_if  in_if ();
  crks_out_if out_if ();
  crks_cfg_if cfg_if ();

  catmull_rom_key_spline_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .cfg_if (cfg_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the key table and key count
  logic [15:0] key_t_q [NumKeys];
  logic [15:0] key_v_q [NumKeys][3];
  int unsigned key_count;

  spline_res_t pending_q [$];
  int  errors = 0;
  int  n_req = 0, n_rsp = 0, n_interp = 0, n_exact = 0, n_clamp = 0;
  int  idle_cycles = 0;
  bit  quiet_sink = 1'b0;
  bit  timed_out = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + (longint'(1) << s) - 1) >>> s);
  endfunction

  function automatic logic [15:0] sat(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic spline_res_t key_res(int k, logic [1:0] st);
    spline_res_t r;
    r.x = key_v_q[k][0]; r.y = key_v_q[k][1]; r.z = key_v_q[k][2]; r.st = st;
    return r;
  endfunction

  // Spline evaluation and table update for one request
  function automatic spline_res_t predict_spline(row_t r);
    spline_res_t res;
    longint basis [4][4] = '{'{-1, 2, -1, 0}, '{3, -5, 0, 2}, '{-3, 4, 1, 0}, '{1, -1, 0, 0}};
    longint w [4];
    longint h, p, acc, s;
    int n, k, kn;
    logic [15:0] o [3];
    s = 65536;
    if (r.op == crks_pkg::OP_WRITE) begin
      key_t_q[r.idx] = r.kt;
      key_v_q[r.idx][0] = r.vx; key_v_q[r.idx][1] = r.vy; key_v_q[r.idx][2] = r.vz;
      res = '{16'h0, 16'h0, 16'h0, crks_pkg::ST_WRITE};
      return res;
    end
    n = key_count;
    if (n < 1) n = 1;
    if (n > NumKeys) n = NumKeys;
    k = 0;
    while (k < n && key_t_q[k] < r.qt) k++;
    if (k >= n) return key_res(n - 1, crks_pkg::ST_CLAMP);
    if (key_t_q[k] == r.qt) return key_res(k, crks_pkg::ST_EXACT);
    if (k == 0) return key_res(0, crks_pkg::ST_CLAMP);
    h = ((longint'(r.qt) - key_t_q[k-1]) << 16) / (longint'(key_t_q[k]) - key_t_q[k-1]);
    for (int i = 0; i < 4; i++) begin
      p = basis[i][0] * h + basis[i][1] * s;
      p = p * h + basis[i][2] * s * s;
      p = p * h + basis[i][3] * s * s * s;
      w[i] = floor_sh(p + (longint'(1) << 32), 33);
    end
    for (int d = 0; d < 3; d++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        kn = k + i - 2;
        if (kn < 0) kn = 0;
        else if (kn > n - 1) kn = n - 1;
        acc += w[i] * longint'($signed(key_v_q[kn][d]));
      end
      o[d] = sat(floor_sh(acc + 32768, 16));
    end
    res = '{o[0], o[1], o[2], crks_pkg::ST_INTERP};
    return res;
  endfunction

  function automatic int rand_idle();
    return (!quiet_sink && $urandom_range(99) < 15);
  endfunction

  // Result sink: random backpressure and field-wise compare
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= !rand_idle();
  end

  always @(posedge clk_i) begin
    spline_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_rsp++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h st=%0d", $time,
                 out_if.out_x, out_if.out_y, out_if.out_z, out_if.status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_if.out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_if.out_x);
          errors++;
        end
        if (out_if.out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_if.out_y);
          errors++;
        end
        if (out_if.out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_if.out_z);
          errors++;
        end
        if (out_if.status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_if.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Leaves valid high on return; the next call drives new data or lowers it, and drain() lowers it
  task automatic send_req(row_t r);
    spline_res_t e;
    while (rand_idle()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{r.op, r.idx, r.kt, r.vx, r.vy, r.vz, r.qt};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    e = predict_spline(r);
    if (r.fixed && e != spline_res_t'({r.ex, r.ey, r.ez, r.est})) begin
      $display("%0t: table row disagrees with predictor", $time);
      errors++;
    end
    pending_q.push_back(e);
    n_req++;
    if (r.op == crks_pkg::OP_QUERY)
      case (e.st)
        crks_pkg::ST_INTERP: n_interp++;
        crks_pkg::ST_EXACT:  n_exact++;
        default:             n_clamp++;
      endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Only called while idle
  task automatic set_key_count(int unsigned v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v[6:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    key_count = v[6:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic row_t wr_row(int i, logic [15:0] t, logic [15:0] x,
                                  logic [15:0] y, logic [15:0] z);
    row_t r;
    r = '{crks_pkg::OP_WRITE, i[5:0], t, x, y, z, 16'($urandom), 1'b1,
          16'h0, 16'h0, 16'h0, crks_pkg::ST_WRITE};
    return r;
  endfunction

  function automatic row_t q_row(logic [15:0] t);
    row_t r;
    r = '{crks_pkg::OP_QUERY, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), t, 1'b0, 16'h0, 16'h0, 16'h0, crks_pkg::ST_INTERP};
    return r;
  endfunction

  // Refill slots 0..n-1 with ascending times, optionally with extreme values
  task automatic load_table(int n, bit extreme);
    int unsigned t, step;
    logic [15:0] v [3];
    step = 65000 / n;
    t = $urandom_range(step / 2);
    for (int i = 0; i < n; i++) begin
      for (int d = 0; d < 3; d++)
        v[d] = extreme ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : 16'($urandom);
      send_req(wr_row(i, t[15:0], v[0], v[1], v[2]));
      t += 1 + $urandom_range(step - 1);
    end
  endtask

  task automatic rand_queries(int n, int cnt);
    int unsigned sel, k;
    for (int j = 0; j < cnt; j++) begin
      sel = $urandom_range(9);
      k = $urandom_range(n - 1);
      if (sel < 2) send_req(q_row(key_t_q[k]));
      else if (sel < 8 && k > 0)
        send_req(q_row(16'($urandom_range(key_t_q[k-1], key_t_q[k]))));
      else send_req(q_row(16'($urandom)));
    end
  endtask

  row_t directed [$];

  initial begin
    int n;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    key_count = 1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single key after reset, extremes, then a small ramp
    directed.push_back(wr_row(0, 16'h8000, 16'h7fff, 16'h8000, 16'h0001));
    directed.push_back('{crks_pkg::OP_QUERY, 6'h3f, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         16'h8000, 1'b1, 16'h7fff, 16'h8000, 16'h0001, crks_pkg::ST_EXACT});
    directed.push_back('{crks_pkg::OP_QUERY, 6'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'h0000, 1'b1, 16'h7fff, 16'h8000, 16'h0001, crks_pkg::ST_CLAMP});
    directed.push_back('{crks_pkg::OP_QUERY, 6'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'hffff, 1'b1, 16'h7fff, 16'h8000, 16'h0001, crks_pkg::ST_CLAMP});
    directed.push_back(wr_row(0, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
    directed.push_back(wr_row(1, 16'h1000, 16'h7fff, 16'h7fff, 16'h7fff));
    directed.push_back(wr_row(2, 16'h2000, 16'h8000, 16'h0000, 16'h7fff));
    directed.push_back(wr_row(3, 16'hffff, 16'h7fff, 16'hffff, 16'h5555));
    directed.push_back(wr_row(63, 16'hffff, 16'haaaa, 16'h5555, 16'hffff));
    foreach (directed[i]) send_req(directed[i]);
    directed.delete();
    drain();
    set_key_count(4);
    directed.push_back(q_row(16'h0000));
    directed.push_back(q_row(16'h0800));
    directed.push_back(q_row(16'h1001));
    directed.push_back(q_row(16'h1fff));
    directed.push_back(q_row(16'h8000));
    directed.push_back(q_row(16'hfffe));
    directed.push_back(q_row(16'hffff));
    foreach (directed[i]) send_req(directed[i]);
    drain();
    // Zero acts as one key, above the table acts as the full table
    set_key_count(0);
    send_req(q_row(16'h0800));
    send_req(q_row(16'h0000));
    drain();
    load_table(64, 1'b1);
    drain();
    set_key_count(127);
    rand_queries(64, 20);
    drain();

    // Random phases over several key counts
    foreach (directed[i]) ;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 2;
        1: n = 64;
        2: n = 1;
        default: n = $urandom_range(2, 20);
      endcase
      quiet_sink = (ph == 4);
      load_table(n, ph == 5);
      drain();
      set_key_count(n);
      rand_queries(n, 60);
      // Sender holds until the block is empty
      drain();
    end
    quiet_sink = 1'b0;
    drain();

    $display("requests %0d, results %0d: %0d interpolated, %0d exact, %0d clamped",
             n_req, n_rsp, n_interp, n_exact, n_clamp);
    $display("key counts 0, 1, 2, 4, 64 and 127 used, extreme key values included");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
